### hw/rtl/imd_pkg.sv
package imd_pkg;

    localparam int unsigned INTERVAL_W = 20;
    localparam int unsigned LIMIT_W    = 48;
    localparam int unsigned META_W     = 12;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned META_SHIFT = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_META_INTERVAL = 2'd0,
        REG_LIMIT_ENABLE  = 2'd1,
        REG_CONTENT_LIMIT = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_AUDIO = 2'd0,
        KIND_META  = 2'd1,
        KIND_LEN   = 2'd2,
        KIND_DROP  = 2'd3
    } kind_t;

    typedef struct packed {
        logic              stream_end;
        logic              meta_last;
        kind_t             byte_kind;
        logic [BYTE_W-1:0] out_byte;
    } result_t;

endpackage

### hw/rtl/imd_classify.sv
module imd_classify
    import imd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data,
    input  logic                 take,
    input  logic [BYTE_W-1:0]    in_byte,
    output result_t              result
);

    localparam logic [LIMIT_W-1:0] COUNT_MAX = {LIMIT_W{1'b1}};

    logic [INTERVAL_W-1:0] meta_interval_reg;
    logic                  limit_enable_reg;
    logic [LIMIT_W-1:0]    content_limit_reg;
    logic [INTERVAL_W-1:0] audio_left_reg, audio_left_next;
    logic                  in_metadata_reg, in_metadata_next;
    logic [META_W-1:0]     meta_left_reg, meta_left_next;
    logic [LIMIT_W-1:0]    delivered_reg, delivered_next;
    logic                  limit_hit;
    logic [META_W-1:0]     meta_dec;
    kind_t                 kind;
    logic                  last;

    assign limit_hit = limit_enable_reg && (delivered_reg >= content_limit_reg);
    assign meta_dec  = meta_left_reg - META_W'(1);

    always_comb
    begin
        kind             = KIND_AUDIO;
        last             = 1'b0;
        audio_left_next  = audio_left_reg;
        in_metadata_next = in_metadata_reg;
        meta_left_next   = meta_left_reg;
        if (limit_hit)
        begin
            kind = KIND_DROP;
        end
        else if (meta_interval_reg == '0)
        begin
            kind = KIND_AUDIO;
        end
        else if (in_metadata_reg && (meta_left_reg != '0))
        begin
            kind           = KIND_META;
            meta_left_next = meta_dec;
            if (meta_dec == '0)
            begin
                last             = 1'b1;
                in_metadata_next = 1'b0;
                audio_left_next  = meta_interval_reg;
            end
        end
        else if (audio_left_reg == '0)
        begin
            kind             = KIND_LEN;
            in_metadata_next = 1'b0;
            if (in_byte == '0)
            begin
                audio_left_next = meta_interval_reg;
            end
            else
            begin
                meta_left_next   = {in_byte, {META_SHIFT{1'b0}}};
                in_metadata_next = 1'b1;
            end
        end
        else
        begin
            audio_left_next = audio_left_reg - INTERVAL_W'(1);
        end

        delivered_next = delivered_reg;
        if ((kind == KIND_AUDIO) && (delivered_reg != COUNT_MAX))
        begin
            delivered_next = delivered_reg + LIMIT_W'(1);
        end
    end

    assign result.out_byte   = in_byte;
    assign result.byte_kind  = kind;
    assign result.meta_last  = last;
    assign result.stream_end = limit_enable_reg && (delivered_next >= content_limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_interval_reg <= '0;
            limit_enable_reg  <= 1'b0;
            content_limit_reg <= '0;
            audio_left_reg    <= '0;
            in_metadata_reg   <= 1'b0;
            meta_left_reg     <= '0;
            delivered_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_META_INTERVAL:
                begin
                    meta_interval_reg <= cfg_data[INTERVAL_W-1:0];
                    audio_left_reg    <= cfg_data[INTERVAL_W-1:0];
                    in_metadata_reg   <= 1'b0;
                    meta_left_reg     <= '0;
                end
                REG_LIMIT_ENABLE:  limit_enable_reg  <= cfg_data[0];
                REG_CONTENT_LIMIT: content_limit_reg <= cfg_data;
                default: ;
            endcase
        end
        else if (take)
        begin
            audio_left_reg  <= audio_left_next;
            in_metadata_reg <= in_metadata_next;
            meta_left_reg   <= meta_left_next;
            delivered_reg   <= delivered_next;
        end
    end

endmodule

### hw/rtl/imd_skid.sv
module imd_skid
    import imd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    push;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || !main_valid_reg)
        begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end
        else if (push)
        begin
            skid_reg <= in_data;
        end
    end

endmodule

### hw/rtl/icy_metadata_demux.sv
// Stream demultiplexer for in-band station metadata.
// The slave side takes one received byte per word in s_tdata. The master side
// returns every byte unchanged in m_tdata, tagged in m_tuser with its kind
// (audio, metadata, length byte or dropped) and with the stream-end flag;
// m_tlast marks the final byte of each metadata block.
// The configuration port sets the metadata interval, the limit enable and the
// content limit. Writing the interval restarts the framing with a full run
// of audio bytes. The user writes only with no word in flight; it is not enforced.
// The classification is combinational and an accepted word is registered in the
// result register, or in the skid register on a stall. Throughput is one word per
// cycle while s_tready is high, set by the counters and the 48-bit limit compare.
// Reset clears the registers, counters and both output stages, so nothing is
// valid on the master side afterwards.
// When the receiver stalls, the result register holds its word and a skid
// register takes one more; s_tready falls only once both are full, and it
// does not depend on m_tready in the same cycle.
module icy_metadata_demux
    import imd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] in_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] out_byte
    output logic                 m_tlast,   // meta_last
    output logic [2:0]           m_tuser    // [1:0] byte_kind, [2] stream_end
);

    result_t result;
    result_t held;
    logic    take;

    assign take = s_tvalid && s_tready;

    imd_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .in_byte   (s_tdata),
        .result    (result)
    );

    imd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (held)
    );

    assign m_tdata = held.out_byte;
    assign m_tlast = held.meta_last;
    assign m_tuser = {held.stream_end, held.byte_kind};

endmodule

### hw/rtl/imd_checker.sv
module imd_checker
    import imd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [2:0] m_tuser
);

    // A stalled word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

    // A stalled word keeps its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("master word changed while stalled");

    // Only a metadata byte can close a metadata block.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1:0] == KIND_META)
    else $error("m_tlast on a byte that is not metadata");

    // A byte is dropped only when the limit was already reached.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == KIND_DROP) |-> m_tuser[2])
    else $error("dropped byte without stream end");

endmodule

bind icy_metadata_demux imd_checker u_imd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
